@@ hdl/assert_macros.svh @@
// assertion macros for the port-level checker file
// each macro expects clk and rst in scope and checks on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LBBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define LBBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lbbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbbs_pkg
// Types and constants shared by the bounce scanner modules.
// ----------------------------------------------------------------------------
package lbbs_pkg;

  // defaults for the top-level parameters
  localparam int MAX_LEDS_DEF      = 8;
  localparam int FRACTION_BITS_DEF = 11;

  // fixed field widths
  localparam int LOAD_W  = 32;
  localparam int WORD_W  = 32;
  localparam int SIZE_W  = 2;
  localparam int DELAY_W = 7;
  localparam int COUNT_W = 4;
  localparam int POS_W   = 5;
  localparam int TABLE_N = 8;
  localparam int TABLE_W = POS_W * TABLE_N;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 5;

  // delay formula constants
  localparam int DELAY_BASE   = 110;
  localparam int DELAY_SPAN   = 300;
  localparam int SPAN_W       = 9;
  localparam int LOAD_DIVISOR = 5;
  localparam int LOAD_OFFSET  = 3;

  // divide by five as a multiply by the rounded-up reciprocal, exact for 32 bits
  localparam logic [LOAD_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam int                DIV5_SHIFT = 34;

  // divider datapath widths
  localparam int DEN_W = 32;
  localparam int Q_W   = DELAY_W;
  localparam int SUB_W = DEN_W + Q_W - 1;
  localparam int CNT_W = $clog2(LOAD_W);

  // register reset values
  localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 4'd8;
  localparam logic [1:0]         ACCESS_RST      = 2'd0;
  localparam logic [TABLE_W-1:0] POS_TABLE_RST   = 40'd247132686368;

  // write-size codes
  localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;

  // register map, one 64-bit slot per register
  typedef enum logic [1:0] {
    REG_LED_COUNT,
    REG_INVERT,
    REG_ACCESS_WIDTH,
    REG_POS_TABLE
  } reg_index_t;

  // configuration bundle from the register file
  typedef struct packed {
    logic [COUNT_W-1:0] led_count;
    logic               invert_output;
    logic [1:0]         access_width;
    logic [TABLE_W-1:0] position_table;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV5,
    S_PREP,
    S_QUOT,
    S_DONE
  } state_t;

endpackage

@@ hdl/lbbs_sub_unit.sv @@
// ----------------------------------------------------------------------------
// lbbs_sub_unit
// Shared compare-and-subtract unit used by every divider step.
// ----------------------------------------------------------------------------
module lbbs_sub_unit #(
  parameter int W = lbbs_pkg::SUB_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // borrow out clear means a >= b
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

@@ hdl/lbbs_regs.sv @@
// ----------------------------------------------------------------------------
// lbbs_regs
// APB register file holding the scanner configuration.
// ----------------------------------------------------------------------------
module lbbs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbbs_pkg::ADDR_W-1:0] paddr,
  input  logic [lbbs_pkg::DATA_W-1:0] pwdata,
  output logic [lbbs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lbbs_pkg::cfg_t              cfg
);

  lbbs_pkg::reg_index_t idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = lbbs_pkg::reg_index_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count      <= lbbs_pkg::LED_COUNT_RST;
      cfg.invert_output  <= 1'b0;
      cfg.access_width   <= lbbs_pkg::ACCESS_RST;
      cfg.position_table <= lbbs_pkg::POS_TABLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        lbbs_pkg::REG_LED_COUNT:    cfg.led_count      <= pwdata[lbbs_pkg::COUNT_W-1:0];
        lbbs_pkg::REG_INVERT:       cfg.invert_output  <= pwdata[0];
        lbbs_pkg::REG_ACCESS_WIDTH: cfg.access_width   <= pwdata[1:0];
        lbbs_pkg::REG_POS_TABLE:    cfg.position_table <= pwdata[lbbs_pkg::TABLE_W-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      lbbs_pkg::REG_LED_COUNT:    prdata = lbbs_pkg::DATA_W'(cfg.led_count);
      lbbs_pkg::REG_INVERT:       prdata = lbbs_pkg::DATA_W'(cfg.invert_output);
      lbbs_pkg::REG_ACCESS_WIDTH: prdata = lbbs_pkg::DATA_W'(cfg.access_width);
      lbbs_pkg::REG_POS_TABLE:    prdata = lbbs_pkg::DATA_W'(cfg.position_table);
    endcase
  end

endmodule

@@ hdl/lbbs_scan.sv @@
// ----------------------------------------------------------------------------
// lbbs_scan
// Bouncing LED index and the register word built from it.
// ----------------------------------------------------------------------------
module lbbs_scan #(
  parameter int MAX_LEDS = lbbs_pkg::MAX_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lbbs_pkg::cfg_t              cfg,
  input  logic                        step,
  output logic [lbbs_pkg::WORD_W-1:0] word,
  output logic [lbbs_pkg::SIZE_W-1:0] size
);

  localparam int IDX_W = $clog2(MAX_LEDS);

  logic [IDX_W-1:0]             scan_index, scan_index_next;
  logic                         moving_down, moving_down_next;
  logic [lbbs_pkg::COUNT_W-1:0] eff_count;
  logic [IDX_W-1:0]             last;
  logic [IDX_W:0]               cand;
  logic [lbbs_pkg::POS_W-1:0]   pos;
  logic [lbbs_pkg::WORD_W-1:0]  onehot;

  // clamp the LED count to 2..MAX_LEDS
  always_comb begin
    priority if (cfg.led_count < lbbs_pkg::COUNT_W'(2)) begin
      eff_count = lbbs_pkg::COUNT_W'(2);
    end else if (cfg.led_count > lbbs_pkg::COUNT_W'(MAX_LEDS)) begin
      eff_count = lbbs_pkg::COUNT_W'(MAX_LEDS);
    end else begin
      eff_count = cfg.led_count;
    end
  end

  assign last = IDX_W'(eff_count - lbbs_pkg::COUNT_W'(1));

  // next index, bouncing at both ends
  always_comb begin
    if (moving_down && scan_index != '0) begin
      cand             = {1'b0, scan_index} - (IDX_W+1)'(1);
      moving_down_next = (cand != '0);
    end else begin
      cand             = {1'b0, scan_index} + (IDX_W+1)'(1);
      moving_down_next = 1'b0;
    end
    if (cand >= {1'b0, last}) begin
      cand             = {1'b0, last};
      moving_down_next = 1'b1;
    end
    scan_index_next = cand[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index  <= '0;
      moving_down <= 1'b0;
    end else if (step) begin
      scan_index  <= scan_index_next;
      moving_down <= moving_down_next;
    end
  end

  // size code, unused code acts as 8-bit
  always_comb begin
    if (cfg.access_width == lbbs_pkg::SIZE_16 || cfg.access_width == lbbs_pkg::SIZE_32) begin
      size = cfg.access_width;
    end else begin
      size = lbbs_pkg::SIZE_8;
    end
  end

  // one-hot word at the table position, inverted and masked
  assign pos    = cfg.position_table[lbbs_pkg::POS_W*int'(scan_index) +: lbbs_pkg::POS_W];
  assign onehot = lbbs_pkg::WORD_W'(1) << pos;

  always_comb begin
    word = cfg.invert_output ? ~onehot : onehot;
    unique case (size)
      lbbs_pkg::SIZE_8:  word = word & lbbs_pkg::WORD_W'(32'h0000_00ff);
      lbbs_pkg::SIZE_16: word = word & lbbs_pkg::WORD_W'(32'h0000_ffff);
      default:           word = word;
    endcase
  end

endmodule

@@ hdl/led_bank_bounce_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// led_bank_bounce_scanner_unit
// Bouncing LED scanner with a load-dependent delay to the next tick.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick carrying load_average. It yields
// one output transaction: led_word (one-hot at the table position of the
// current index, optionally inverted, masked to the access width),
// write_size and next_delay = 110 - (300 << F) / (load_average / 5 + (3 << F)).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. The APB port holds led_count, invert_output, access_width and
// position_table at byte addresses 0, 8, 16 and 24; write it only while idle.
// The divide by five is a reciprocal multiply, then a setup state and 7 restoring
// quotient steps through one shared subtractor, then a load of the output
// register. in_stall is high from acceptance until the result is loaded, so
// a new tick is taken only once the previous result has been loaded.
// A stalled result holds in the output register while the next tick is
// already being worked on; that tick waits for the register to free up.
// Reset restores the register defaults, index 0 moving up, and empties the
// output register.
// ----------------------------------------------------------------------------
module led_bank_bounce_scanner_unit #(
  parameter int MAX_LEDS      = lbbs_pkg::MAX_LEDS_DEF,
  parameter int FRACTION_BITS = lbbs_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lbbs_pkg::LOAD_W-1:0]  load_average,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbbs_pkg::WORD_W-1:0]  led_word,
  output logic [lbbs_pkg::SIZE_W-1:0]  write_size,
  output logic [lbbs_pkg::DELAY_W-1:0] next_delay,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lbbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [lbbs_pkg::DATA_W-1:0]  pwdata,
  output logic [lbbs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int NUM_W = lbbs_pkg::SPAN_W + FRACTION_BITS;
  localparam logic [NUM_W-1:0] NUMER =
    NUM_W'(lbbs_pkg::DELAY_SPAN) << FRACTION_BITS;
  localparam logic [lbbs_pkg::DEN_W-1:0] OFFSET =
    lbbs_pkg::DEN_W'(lbbs_pkg::LOAD_OFFSET) << FRACTION_BITS;

  lbbs_pkg::state_t              state, state_next;
  lbbs_pkg::cfg_t                cfg;
  logic [lbbs_pkg::LOAD_W-1:0]   load_sh;
  logic [2*lbbs_pkg::LOAD_W-1:0] div5_prod;
  logic [NUM_W-1:0]              num;
  logic [lbbs_pkg::SUB_W-1:0]    dsh;
  logic [lbbs_pkg::Q_W-1:0]      quot;
  logic [lbbs_pkg::CNT_W-1:0]    cnt;
  logic [lbbs_pkg::SUB_W-1:0]    op_a, op_b, sub_diff;
  logic                          sub_ge;
  logic                          out_load;
  logic [lbbs_pkg::WORD_W-1:0]   scan_word;
  logic [lbbs_pkg::SIZE_W-1:0]   scan_size;

  lbbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbbs_scan #(
    .MAX_LEDS (MAX_LEDS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (out_load),
    .word (scan_word),
    .size (scan_size)
  );

  // load / 5 by reciprocal multiply, upper bits of the product
  assign div5_prod = {{lbbs_pkg::LOAD_W{1'b0}}, load_sh} *
                     {{lbbs_pkg::LOAD_W{1'b0}}, lbbs_pkg::DIV5_RECIP};

  // operands for the shared subtractor
  assign op_a = lbbs_pkg::SUB_W'(num);
  assign op_b = dsh;

  lbbs_sub_unit #(
    .W (lbbs_pkg::SUB_W)
  ) u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lbbs_pkg::S_IDLE: if (in_valid) state_next = lbbs_pkg::S_DIV5;
      lbbs_pkg::S_DIV5: state_next = lbbs_pkg::S_PREP;
      lbbs_pkg::S_PREP: state_next = lbbs_pkg::S_QUOT;
      lbbs_pkg::S_QUOT: if (cnt == '0) state_next = lbbs_pkg::S_DONE;
      lbbs_pkg::S_DONE: if (!out_valid || !out_stall) state_next = lbbs_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state != lbbs_pkg::S_IDLE);
    out_load = (state == lbbs_pkg::S_DONE) && (!out_valid || !out_stall);
  end

  // divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lbbs_pkg::S_IDLE: begin
        load_sh <= load_average;
      end
      lbbs_pkg::S_DIV5: begin
        load_sh <= lbbs_pkg::LOAD_W'(div5_prod >> lbbs_pkg::DIV5_SHIFT);
      end
      lbbs_pkg::S_PREP: begin
        dsh  <= {load_sh + OFFSET, {(lbbs_pkg::Q_W-1){1'b0}}};
        num  <= NUMER;
        quot <= '0;
        cnt  <= lbbs_pkg::CNT_W'(lbbs_pkg::Q_W - 1);
      end
      lbbs_pkg::S_QUOT: begin
        if (sub_ge) begin
          num <= sub_diff[NUM_W-1:0];
        end
        quot <= {quot[lbbs_pkg::Q_W-2:0], sub_ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - lbbs_pkg::CNT_W'(1);
      end
      lbbs_pkg::S_DONE: begin
        cnt <= cnt;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      led_word   <= scan_word;
      write_size <= scan_size;
      next_delay <= lbbs_pkg::DELAY_W'(lbbs_pkg::DELAY_BASE) - quot;
    end
  end

endmodule

@@ hdl/lbbs_checker.sv @@
// ----------------------------------------------------------------------------
// lbbs_checker
// Port-level checks for the bounce scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lbbs_pkg::WORD_W-1:0]  led_word,
  input logic [lbbs_pkg::SIZE_W-1:0]  write_size,
  input logic [lbbs_pkg::DELAY_W-1:0] next_delay
);

  // block goes busy right after taking a transaction
  `LBBS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

  // delay always lands in its range
  `LBBS_ASSERT_NOW(a_delay_range, out_valid, next_delay >= 7'd10 && next_delay <= 7'd110, "delay out of range")

  // with an 8-bit write size the word never carries bits above bit 7
  `LBBS_ASSERT_NOW(a_word_masked, out_valid && write_size == lbbs_pkg::SIZE_8, led_word[31:8] == 24'd0, "word wider than 8 bits")

  // a stalled result is not dropped
  `LBBS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(next_delay), "stalled result lost")

endmodule

bind led_bank_bounce_scanner_unit lbbs_checker u_lbbs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .led_word   (led_word),
  .write_size (write_size),
  .next_delay (next_delay)
);

@@ sim/bounce_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounce_scan_checker
// Watches the tick and result channels of the bounce scanner and checks them.
// ----------------------------------------------------------------------------
// Mirrors every register write seen on the APB port, keeps its own copy of
// the scan index and direction, and works out the LED word, write size and
// next delay for each accepted tick. Results are compared in order against
// the queue of pending ticks; mismatches and stray results are counted.
// ----------------------------------------------------------------------------
module bounce_scan_checker
  import lbbs_pkg::*;
#(
  parameter int MAX_LEDS      = MAX_LEDS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [LOAD_W-1:0]  load_average,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [WORD_W-1:0]  led_word,
  input  logic [SIZE_W-1:0]  write_size,
  input  logic [DELAY_W-1:0] next_delay,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [SIZE_W-1:0]  size;
    logic [DELAY_W-1:0] delay;
  } tick_result_t;

  cfg_t         shadow_cfg;
  logic [2:0]   scan_pos;
  logic         heading_down;
  tick_result_t pending_ticks[$];
  tick_result_t due;
  int           mismatches = 0;

  // light the current led, work out the delay, then bounce the index
  function automatic tick_result_t light_next(input logic [LOAD_W-1:0] load);
    tick_result_t r;
    logic [POS_W-1:0] bit_pos;
    logic [63:0] den;
    logic [63:0] quo;
    int span;
    int last;
    int nxt;
    if (shadow_cfg.access_width == SIZE_16 || shadow_cfg.access_width == SIZE_32) begin
      r.size = shadow_cfg.access_width;
    end else begin
      r.size = SIZE_8;
    end
    bit_pos = shadow_cfg.position_table[POS_W*scan_pos +: POS_W];
    r.word = 32'd1 << bit_pos;
    if (shadow_cfg.invert_output) begin
      r.word = ~r.word;
    end
    if (r.size == SIZE_8) begin
      r.word &= 32'h0000_00FF;
    end else if (r.size == SIZE_16) begin
      r.word &= 32'h0000_FFFF;
    end
    // truncating unsigned divide, done wide so nothing wraps
    den = 64'(load) / LOAD_DIVISOR + (64'(LOAD_OFFSET) << FRACTION_BITS);
    quo = (64'(DELAY_SPAN) << FRACTION_BITS) / den;
    r.delay = DELAY_W'(64'(DELAY_BASE) - quo);
    // out-of-range counts clamp to 2..MAX_LEDS
    span = int'(shadow_cfg.led_count);
    if (span < 2) begin
      span = 2;
    end
    if (span > MAX_LEDS) begin
      span = MAX_LEDS;
    end
    last = span - 1;
    if (heading_down && scan_pos != 3'd0) begin
      nxt = int'(scan_pos) - 1;
      if (nxt == 0) begin
        heading_down = 1'b0;
      end
    end else begin
      nxt = int'(scan_pos) + 1;
      heading_down = 1'b0;
    end
    // reaching or passing the top end turns the scan around
    if (nxt >= last) begin
      nxt = last;
      heading_down = 1'b1;
    end
    scan_pos = nxt[2:0];
    return r;
  endfunction

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.led_count      = LED_COUNT_RST;
      shadow_cfg.invert_output  = 1'b0;
      shadow_cfg.access_width   = ACCESS_RST;
      shadow_cfg.position_table = POS_TABLE_RST;
      scan_pos     = 3'd0;
      heading_down = 1'b0;
      pending_ticks.delete();
    end else begin
      // register writes, excess bits dropped
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_W-1:3]))
          REG_LED_COUNT:    shadow_cfg.led_count      = pwdata[COUNT_W-1:0];
          REG_INVERT:       shadow_cfg.invert_output  = pwdata[0];
          REG_ACCESS_WIDTH: shadow_cfg.access_width   = pwdata[1:0];
          REG_POS_TABLE:    shadow_cfg.position_table = pwdata[TABLE_W-1:0];
          default: ;
        endcase
      end
      // tick transaction
      if (in_valid && !in_stall) begin
        pending_ticks.push_back(light_next(load_average));
      end
      // result transaction
      if (out_valid && !out_stall) begin
        if (pending_ticks.size() == 0) begin
          $error("result with no tick pending: led_word %h write_size %0d next_delay %0d",
                 led_word, write_size, next_delay);
          mismatches++;
        end else begin
          due = pending_ticks.pop_front();
          if (led_word !== due.word) begin
            $error("led_word: expected %h, got %h", due.word, led_word);
            mismatches++;
          end
          if (write_size !== due.size) begin
            $error("write_size: expected %0d, got %0d", due.size, write_size);
            mismatches++;
          end
          if (next_delay !== due.delay) begin
            $error("next_delay: expected %0d, got %0d", due.delay, next_delay);
            mismatches++;
          end
        end
      end
    end
    outstanding <= pending_ticks.size();
    fail_count  <= mismatches;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bouncing LED scanner.
// ----------------------------------------------------------------------------
// Sends a directed set of corner loads under several register settings, then
// random phases, each with its own register setting, draining all results
// before every register update. Both sides idle at random, with a calm
// stretch and one long receiver hold that backs the scanner up. The checker
// beside the block does all prediction; this module only reports its count.
// ----------------------------------------------------------------------------
module tb_top;
  import lbbs_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 130;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_LEN      = 400;
  localparam int CALM_FROM     = 600;
  localparam int CALM_TO       = 700;
  localparam int IDLE_PCT      = 16;
  localparam int SETTLE_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [LOAD_W-1:0]  load_average = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  led_word;
  logic [SIZE_W-1:0]  write_size;
  logic [DELAY_W-1:0] next_delay;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 outstanding;
  int unsigned        ticks_sent = 0;

  led_bank_bounce_scanner_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .load_average (load_average),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_word     (led_word),
    .write_size   (write_size),
    .next_delay   (next_delay),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bounce_scan_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .load_average (load_average),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_word     (led_word),
    .write_size   (write_size),
    .next_delay   (next_delay),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall, a calm stretch and one long hold
  initial begin : receiver
    int unsigned results_taken;
    bit calm;
    results_taken = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_taken++;
        if (results_taken == HOLD_AT) begin
          out_stall <= 1'b1;
          repeat (HOLD_LEN) @(posedge clk);
        end
      end
      calm = results_taken >= CALM_FROM && results_taken < CALM_TO;
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // one tick transaction, with a random gap in front of it
  task automatic send_tick(input logic [LOAD_W-1:0] load);
    bit calm;
    calm = ticks_sent >= CALM_FROM && ticks_sent < CALM_TO;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    load_average <= load;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // apb write: setup, access, then back to idle
  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write all four registers, upper bits filled with junk
  task automatic set_config(input logic [COUNT_W-1:0] count, input logic inv,
                            input logic [1:0] width, input logic [TABLE_W-1:0] positions);
    logic [DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_LED_COUNT, {junk[DATA_W-1:COUNT_W], count});
    junk = {$urandom, $urandom};
    write_reg(REG_INVERT, {junk[DATA_W-1:1], inv});
    junk = {$urandom, $urandom};
    write_reg(REG_ACCESS_WIDTH, {junk[DATA_W-1:2], width});
    junk = {$urandom, $urandom};
    write_reg(REG_POS_TABLE, {junk[DATA_W-1:TABLE_W], positions});
  endtask

  // main stimulus
  initial begin : stimulus
    logic [LOAD_W-1:0] corner_loads [22];
    logic [LOAD_W-1:0] load;
    logic [63:0]       shuffled;
    int unsigned       pick;
    corner_loads = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0005,
      32'h7FFF_FFFF, 32'h8000_0000, 32'd30719,     32'd30720,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
      32'h0000_1000, 32'h0001_0000, 32'h0100_0000, 32'hFFFF_FFFE,
      32'h0000_0004, 32'h0000_0006, 32'd3072000,   32'h00FF_FFFF,
      32'h1234_5678, 32'd3000
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner loads under reset settings, index climbs to four
    for (int i = 0; i < 4; i++) send_tick(corner_loads[i]);
    // count lowered below the index, inverted, unused width code
    drain();
    set_config(4'd3, 1'b1, 2'd3, POS_TABLE_RST);
    for (int i = 4; i < 8; i++) send_tick(corner_loads[i]);
    // count above the maximum, full width, top bit lit
    drain();
    set_config(4'd15, 1'b0, SIZE_32, '1);
    for (int i = 8; i < 16; i++) send_tick(corner_loads[i]);
    // count below the minimum, half width, bit zero lit
    drain();
    set_config(4'd0, 1'b1, SIZE_16, '0);
    for (int i = 16; i < 22; i++) send_tick(corner_loads[i]);

    // random phases, each with its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      shuffled = {$urandom, $urandom};
      case (p)
        0: set_config(4'd8, 1'b0, SIZE_8, POS_TABLE_RST);
        1: set_config(4'd2, 1'b1, SIZE_16, shuffled[TABLE_W-1:0]);
        2: set_config(4'd15, 1'b0, SIZE_32, shuffled[TABLE_W-1:0]);
        3: set_config(4'd0, 1'b1, 2'd3, '1);
        4: set_config(4'd5, 1'b0, SIZE_32, shuffled[TABLE_W-1:0]);
        5: set_config(4'd1, 1'b1, SIZE_32, shuffled[TABLE_W-1:0]);
        6: set_config(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      2'($urandom_range(0, 3)), shuffled[TABLE_W-1:0]);
        default: set_config(4'd3, 1'b0, SIZE_16, '0);
      endcase
      repeat (PHASE_TICKS) begin
        // half full-range loads, the rest in the range where the delay moves
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          load = $urandom;
        end else if (pick < 8) begin
          load = $urandom_range(0, 32'h0010_0000);
        end else begin
          load = $urandom_range(0, 64);
        end
        send_tick(load);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
